// File: src/fcce_pkg.sv
// Package for the FAT16 cluster chain engine: constants, codes and shared types.
`default_nettype none
package fcce_pkg;

  localparam int FAT_ENTRIES_DEF = 1024;
  localparam int MAX_CHAIN       = 128;
  localparam int CLUSTER_BYTES   = 2048;
  localparam int CLUSTER_SHIFT   = $clog2(CLUSTER_BYTES);
  localparam int SCAN_LIMIT      = 1000;
  localparam int ADDR_W          = 16;
  localparam int LINK_W          = 16;
  localparam int INDEX_W         = 10;
  localparam int COUNT_W         = 8;

  localparam logic [LINK_W-1:0] END_MARK  = 16'hFFFF;
  localparam logic [LINK_W-1:0] FREE_LINK = 16'h0000;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_READ,
    OP_WRITE
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOSPACE,
    ST_BADCHAIN,
    ST_TOOMANY
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT,
    S_LNK,
    S_END,
    S_FCHK,
    S_FCHW,
    S_FCLR,
    S_FCLW,
    S_RDW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;
  } tbl_req_t;

endpackage
`default_nettype wire

// File: src/fcce_tbl.sv
// Cluster link table memory with its clearing pass after reset.
`default_nettype none
module fcce_tbl
  import fcce_pkg::*;
#(
  parameter int FAT_ENTRIES = FAT_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tbl_req_t          req,
  output logic [LINK_W-1:0]      rd_data,
  output logic                   ready
);

  localparam int AW = $clog2(FAT_ENTRIES);

  logic [LINK_W-1:0] mem [FAT_ENTRIES];
  logic              clr_busy;
  logic [AW-1:0]     clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(FAT_ENTRIES - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= FREE_LINK;
    end else if (req.we) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[req.rd_addr[AW-1:0]];
  end

  assign ready = !clr_busy;

endmodule
`default_nettype wire

// File: src/fcce_ctrl.sv
// Sequencer for allocate, free, read and write, with the result register.
`default_nettype none
module fcce_ctrl
  import fcce_pkg::*;
#(
  parameter int FAT_ENTRIES = FAT_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire op_t                in_op,
  input  wire logic [31:0]        in_size,
  input  wire logic [INDEX_W-1:0] in_idx,
  input  wire logic [LINK_W-1:0]  in_val,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output status_t                 out_status,
  output logic [INDEX_W-1:0]      out_first,
  output logic [COUNT_W-1:0]      out_count,
  output logic [LINK_W-1:0]       out_link,
  output tbl_req_t                req,
  input  wire logic [LINK_W-1:0]  rd_data,
  input  wire logic               tbl_ready
);

  localparam int SCAN_END = (SCAN_LIMIT < FAT_ENTRIES) ? SCAN_LIMIT : FAT_ENTRIES;
  localparam int SW       = $clog2(SCAN_END + 1);
  localparam int NEED_W   = 33 - CLUSTER_SHIFT;
  localparam logic [16:0]        ENTRIES  = 17'(FAT_ENTRIES);
  localparam logic [SW-1:0]      SCAN_TOP = SW'(SCAN_END);
  localparam logic [SW-1:0]      SCAN_BOT = SW'(2);
  localparam logic [COUNT_W-1:0] CHAIN_MAX = COUNT_W'(MAX_CHAIN);

  state_t               state, state_next;
  logic [SW-1:0]        scan, scan_next;
  logic                 p_valid, p_valid_next;
  logic [SW-1:0]        p_idx, p_idx_next;
  logic [COUNT_W-1:0]   found, found_next;
  logic [COUNT_W-1:0]   need, need_next;
  logic                 have_prev, have_prev_next;
  logic [SW-1:0]        prev, prev_next;
  logic [SW-1:0]        head, head_next;
  logic [LINK_W-1:0]    cur, cur_next;
  logic [INDEX_W-1:0]   start, start_next;
  logic [COUNT_W-1:0]   len, len_next;
  status_t              res_status, res_status_next;
  logic [INDEX_W-1:0]   res_first, res_first_next;
  logic [COUNT_W-1:0]   res_count, res_count_next;
  logic [LINK_W-1:0]    res_link, res_link_next;
  logic                 out_valid_next;
  status_t              out_status_next;
  logic [INDEX_W-1:0]   out_first_next;
  logic [COUNT_W-1:0]   out_count_next;
  logic [LINK_W-1:0]    out_link_next;

  logic                 hit;
  logic                 issue;
  logic [COUNT_W-1:0]   found_inc;
  logic [32:0]          size_up;
  logic [NEED_W-1:0]    need_raw;
  logic [NEED_W-1:0]    need_eff;
  logic                 cur_ok;
  logic                 idx_ok;

  assign in_ready  = (state == S_IDLE) && tbl_ready;
  assign hit       = p_valid && (rd_data == FREE_LINK);
  assign issue     = scan < SCAN_TOP;
  assign found_inc = found + {{(COUNT_W-1){1'b0}}, hit};
  assign size_up   = {1'b0, in_size} + 33'(CLUSTER_BYTES - 1);
  assign need_raw  = size_up[32:CLUSTER_SHIFT];
  assign need_eff  = (need_raw == '0) ? NEED_W'(1) : need_raw;
  assign cur_ok    = ({1'b0, cur} >= 17'd2) && ({1'b0, cur} < ENTRIES);
  assign idx_ok    = {7'b0, in_idx} < ENTRIES;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan       <= scan_next;
    p_valid    <= p_valid_next;
    p_idx      <= p_idx_next;
    found      <= found_next;
    need       <= need_next;
    have_prev  <= have_prev_next;
    prev       <= prev_next;
    head       <= head_next;
    cur        <= cur_next;
    start      <= start_next;
    len        <= len_next;
    res_status <= res_status_next;
    res_first  <= res_first_next;
    res_count  <= res_count_next;
    res_link   <= res_link_next;
    out_status <= out_status_next;
    out_first  <= out_first_next;
    out_count  <= out_count_next;
    out_link   <= out_link_next;
  end

  always_comb begin
    state_next      = state;
    scan_next       = scan;
    p_valid_next    = p_valid;
    p_idx_next      = p_idx;
    found_next      = found;
    need_next       = need;
    have_prev_next  = have_prev;
    prev_next       = prev;
    head_next       = head;
    cur_next        = cur;
    start_next      = start;
    len_next        = len;
    res_status_next = res_status;
    res_first_next  = res_first;
    res_count_next  = res_count;
    res_link_next   = res_link;
    out_valid_next  = out_valid && !out_ready;
    out_status_next = out_status;
    out_first_next  = out_first;
    out_count_next  = out_count;
    out_link_next   = out_link;
    req             = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid && tbl_ready) begin
          res_status_next = ST_OK;
          res_first_next  = '0;
          res_count_next  = '0;
          res_link_next   = '0;
          unique case (in_op)
            OP_ALLOC: begin
              if (need_eff > NEED_W'(MAX_CHAIN)) begin
                res_status_next = ST_TOOMANY;
                state_next      = S_DONE;
              end else begin
                need_next    = COUNT_W'(need_eff);
                scan_next    = SCAN_BOT;
                p_valid_next = 1'b0;
                found_next   = '0;
                state_next   = S_CNT;
              end
            end
            OP_FREE: begin
              cur_next   = {{(LINK_W-INDEX_W){1'b0}}, in_idx};
              start_next = in_idx;
              len_next   = '0;
              state_next = S_FCHK;
            end
            OP_READ: begin
              req.rd_addr = ADDR_W'(in_idx);
              state_next  = idx_ok ? S_RDW : S_DONE;
            end
            OP_WRITE: begin
              req.we      = idx_ok;
              req.wr_addr = ADDR_W'(in_idx);
              req.wr_data = in_val;
              state_next  = S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_RDW: begin
        res_link_next = rd_data;
        state_next    = S_DONE;
      end
      S_CNT: begin
        req.rd_addr  = ADDR_W'(scan);
        scan_next    = issue ? scan + 1'b1 : scan;
        p_valid_next = issue;
        p_idx_next   = scan;
        found_next   = found_inc;
        if (found_inc == need) begin
          scan_next      = SCAN_BOT;
          p_valid_next   = 1'b0;
          found_next     = '0;
          have_prev_next = 1'b0;
          state_next     = S_LNK;
        end else if (!issue && !p_valid) begin
          res_status_next = ST_NOSPACE;
          state_next      = S_DONE;
        end
      end
      S_LNK: begin
        req.rd_addr  = ADDR_W'(scan);
        scan_next    = issue ? scan + 1'b1 : scan;
        p_valid_next = issue;
        p_idx_next   = scan;
        found_next   = found_inc;
        if (hit) begin
          req.we         = have_prev;
          req.wr_addr    = ADDR_W'(prev);
          req.wr_data    = LINK_W'(p_idx);
          head_next      = have_prev ? head : p_idx;
          prev_next      = p_idx;
          have_prev_next = 1'b1;
        end
        if (found_inc == need) begin
          state_next = S_END;
        end
      end
      S_END: begin
        req.we         = 1'b1;
        req.wr_addr    = ADDR_W'(prev);
        req.wr_data    = END_MARK;
        res_first_next = INDEX_W'(head);
        res_count_next = found;
        state_next     = S_DONE;
      end
      S_FCHK: begin
        if (!cur_ok || (len >= CHAIN_MAX)) begin
          res_status_next = ST_BADCHAIN;
          state_next      = S_DONE;
        end else begin
          req.rd_addr = ADDR_W'(cur);
          state_next  = S_FCHW;
        end
      end
      S_FCHW: begin
        len_next = len + 1'b1;
        if (rd_data == FREE_LINK) begin
          res_status_next = ST_BADCHAIN;
          state_next      = S_DONE;
        end else if (rd_data == END_MARK) begin
          cur_next   = {{(LINK_W-INDEX_W){1'b0}}, start};
          state_next = S_FCLR;
        end else begin
          cur_next   = rd_data;
          state_next = S_FCHK;
        end
      end
      S_FCLR: begin
        req.rd_addr = ADDR_W'(cur);
        state_next  = S_FCLW;
      end
      S_FCLW: begin
        req.we      = 1'b1;
        req.wr_addr = ADDR_W'(cur);
        req.wr_data = FREE_LINK;
        if (rd_data == END_MARK) begin
          res_count_next = len;
          state_next     = S_DONE;
        end else begin
          cur_next   = rd_data;
          state_next = S_FCLR;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_first_next  = res_first;
          out_count_next  = res_count;
          out_link_next   = res_link;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !tbl_ready |-> !out_valid)
    else $error("Result presented during the table clearing pass.");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input ready again straight after a transfer.");

  a_error_clears_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != ST_OK) |-> (out_count == '0) && (out_first == '0))
    else $error("Failed operation reports a chain head or count.");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count <= CHAIN_MAX)
    else $error("Cluster count beyond the chain limit.");

endmodule
`default_nettype wire

// File: src/fat16_cluster_chain_engine_top.sv
// Top level of the FAT16 cluster chain engine: stream ports, sequencer and link table.
// Allocate makes a counting scan and a linking scan of the table; free makes a checking walk
// and a clearing walk along the chain.
// One item is worked on at a time; the next transfer is taken while a result still waits.
// After rst the table is cleared one entry a cycle, with s_tready low.
`default_nettype none
module fat16_cluster_chain_engine_top
  import fcce_pkg::*;
#(
  parameter int FAT_ENTRIES = FAT_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // size_bytes[31:0], cluster_index[41:32], entry_value[57:42]
  input  wire logic [1:0]  s_tuser,  // opcode[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // first_cluster[9:0], cluster_count[17:10], link_value[33:18]
  output logic [1:0]       m_tuser   // status[1:0]
);

  tbl_req_t           req;
  logic [LINK_W-1:0]  rd_data;
  logic               tbl_ready;
  status_t            out_status;
  logic [INDEX_W-1:0] out_first;
  logic [COUNT_W-1:0] out_count;
  logic [LINK_W-1:0]  out_link;

  fcce_ctrl #(
    .FAT_ENTRIES(FAT_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (op_t'(s_tuser)),
    .in_size   (s_tdata[31:0]),
    .in_idx    (s_tdata[41:32]),
    .in_val    (s_tdata[57:42]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_status(out_status),
    .out_first (out_first),
    .out_count (out_count),
    .out_link  (out_link),
    .req       (req),
    .rd_data   (rd_data),
    .tbl_ready (tbl_ready)
  );

  fcce_tbl #(
    .FAT_ENTRIES(FAT_ENTRIES)
  ) u_tbl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rd_data(rd_data),
    .ready  (tbl_ready)
  );

  assign m_tdata = {6'b0, out_link, out_count, out_first};
  assign m_tuser = out_status;

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the FAT16 cluster chain engine with a built-in predictor.
`timescale 1ns / 100ps
module tb;
  import fcce_pkg::*;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    op_t         op;
    logic [31:0] size_bytes;
    logic [9:0]  cluster_index;
    logic [15:0] entry_value;
    bit          pick_live;
  } fat_cmd_t;

  typedef struct {
    status_t     status;
    logic [9:0]  first_cluster;
    logic [7:0]  cluster_count;
    logic [15:0] link_value;
  } fat_result_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  logic [15:0] fat_model [0:FAT_ENTRIES_DEF-1] = '{default: '0};
  int unsigned live_heads [$];
  fat_cmd_t    pending_cmds [$];
  fat_result_t results_due [$];
  fat_cmd_t    held_cmd;
  fat_result_t want_res;

  int unsigned gap_max = 6;
  int unsigned stall_max = 6;
  int unsigned gap_left, stall_left, hold_left, quiet_cycles;
  int unsigned n_sent, n_results, n_errors;
  int unsigned n_alloc, n_nospace, n_toomany, n_free, n_badchain, n_read, n_write;

  fat16_cluster_chain_engine_top uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one command to the local copy of the table and returns the result it should give.
  function automatic fat_result_t fat_apply(fat_cmd_t c);
    fat_result_t     r;
    longint unsigned need;
    int unsigned     win_end, found, i, prev, head, cur, len;
    logic [15:0]     v;
    bit              bad, done;
    int              k;
    r.status = ST_OK;
    r.first_cluster = '0;
    r.cluster_count = '0;
    r.link_value = '0;
    win_end = (SCAN_LIMIT < FAT_ENTRIES_DEF) ? SCAN_LIMIT : FAT_ENTRIES_DEF;
    case (c.op)
      OP_ALLOC: begin
        n_alloc++;
        need = ({32'd0, c.size_bytes} + CLUSTER_BYTES - 1) / CLUSTER_BYTES;
        if (need == 0) need = 1;
        if (need > MAX_CHAIN) begin
          r.status = ST_TOOMANY;
          n_toomany++;
        end else begin
          found = 0;
          for (i = 2; i < win_end && found < need; i++)
            if (fat_model[i] == FREE_LINK) found++;
          if (found < need) begin
            r.status = ST_NOSPACE;
            n_nospace++;
          end else begin
            found = 0;
            prev = 0;
            head = 0;
            for (i = 2; i < win_end && found < need; i++) begin
              if (fat_model[i] == FREE_LINK) begin
                if (found == 0) head = i;
                else fat_model[prev] = i[15:0];
                prev = i;
                found++;
              end
            end
            fat_model[prev] = END_MARK;
            r.first_cluster = head[9:0];
            r.cluster_count = found[7:0];
            live_heads.push_back(head);
          end
        end
      end
      OP_FREE: begin
        n_free++;
        cur = c.cluster_index;
        len = 0;
        bad = 1'b0;
        done = 1'b0;
        while (!bad && !done) begin
          if (cur < 2 || cur >= FAT_ENTRIES_DEF || len >= MAX_CHAIN) begin
            bad = 1'b1;
          end else begin
            v = fat_model[cur];
            len++;
            if (v == FREE_LINK) bad = 1'b1;
            else if (v == END_MARK) done = 1'b1;
            else cur = v;
          end
        end
        if (bad) begin
          r.status = ST_BADCHAIN;
          n_badchain++;
        end else begin
          cur = c.cluster_index;
          do begin
            v = fat_model[cur];
            fat_model[cur] = FREE_LINK;
            cur = v;
          end while (v != END_MARK);
          r.cluster_count = len[7:0];
        end
        for (k = 0; k < live_heads.size(); k++) begin
          if (live_heads[k] == c.cluster_index) begin
            live_heads.delete(k);
            break;
          end
        end
      end
      OP_READ: begin
        n_read++;
        r.link_value = fat_model[c.cluster_index];
      end
      default: begin
        n_write++;
        fat_model[c.cluster_index] = c.entry_value;
      end
    endcase
    return r;
  endfunction

  function automatic void queue_cmd(op_t op, logic [31:0] sz, logic [9:0] ix, logic [15:0] v,
                                    bit live);
    fat_cmd_t c;
    c.op = op;
    c.size_bytes = sz;
    c.cluster_index = ix;
    c.entry_value = v;
    c.pick_live = live;
    pending_cmds.push_back(c);
  endfunction

  // Mostly allocations and frees of chains still held, with some reads, stray frees and writes.
  function automatic void queue_random_cmd();
    int unsigned roll, pick;
    logic [31:0] sz;
    logic [9:0]  ix;
    logic [15:0] v;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    sz = $urandom();
    ix = $urandom_range(0, 1023);
    v = $urandom_range(0, 65535);
    if (roll < 40) begin
      if (pick < 80) sz = $urandom_range(0, 6 * CLUSTER_BYTES);
      else if (pick < 95) sz = $urandom_range(0, MAX_CHAIN * CLUSTER_BYTES);
      queue_cmd(OP_ALLOC, sz, ix, v, 1'b0);
    end else if (roll < 70) begin
      queue_cmd(OP_FREE, sz, ix, v, 1'b1);
    end else if (roll < 75) begin
      queue_cmd(OP_FREE, sz, ix, v, 1'b0);
    end else if (roll < 92) begin
      queue_cmd(OP_READ, sz, ix, v, 1'b0);
    end else begin
      if (pick < 50) v = FREE_LINK;
      queue_cmd(OP_WRITE, sz, ix, v, 1'b0);
    end
  endfunction

  task automatic drain();
    while (pending_cmds.size() != 0 || s_tvalid || results_due.size() != 0) @(negedge clk);
  endtask

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        results_due.push_back(fat_apply(held_cmd));
        n_sent++;
        gap_left = $urandom_range(0, gap_max);
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          held_cmd = pending_cmds.pop_front();
          if (held_cmd.pick_live && live_heads.size() != 0)
            held_cmd.cluster_index = live_heads[$urandom_range(0, live_heads.size() - 1)];
          s_tdata <= {6'd0, held_cmd.entry_value, held_cmd.cluster_index, held_cmd.size_bytes};
          s_tuser <= held_cmd.op;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, status %0d, data 0x%0h", $time, m_tuser, m_tdata);
          n_errors++;
        end else begin
          want_res = results_due.pop_front();
          report_field("status", want_res.status, m_tuser);
          report_field("first_cluster", want_res.first_cluster, m_tdata[9:0]);
          report_field("cluster_count", want_res.cluster_count, m_tdata[17:10]);
          report_field("link_value", want_res.link_value, m_tdata[33:18]);
        end
        n_results++;
        stall_left = $urandom_range(0, stall_max);
        if (n_results == 120 || n_results == 380) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_cmd(OP_READ, 32'd0, 10'd0, 16'h0000, 1'b0);
    queue_cmd(OP_READ, 32'hFFFF_FFFF, 10'd1023, 16'hFFFF, 1'b0);
    queue_cmd(OP_ALLOC, 32'd0, 10'd0, 16'h0000, 1'b0);
    queue_cmd(OP_ALLOC, 32'd1, 10'd0, 16'h0000, 1'b0);
    queue_cmd(OP_ALLOC, CLUSTER_BYTES, 10'd0, 16'h0000, 1'b0);
    queue_cmd(OP_ALLOC, CLUSTER_BYTES + 1, 10'd0, 16'h0000, 1'b0);
    queue_cmd(OP_ALLOC, MAX_CHAIN * CLUSTER_BYTES, 10'd0, 16'h0000, 1'b0);
    queue_cmd(OP_ALLOC, MAX_CHAIN * CLUSTER_BYTES + 1, 10'd0, 16'h0000, 1'b0);
    queue_cmd(OP_ALLOC, 32'hFFFF_FFFF, 10'd1023, 16'hFFFF, 1'b0);
    queue_cmd(OP_FREE, 32'd0, 10'd5, 16'h0000, 1'b0);
    queue_cmd(OP_FREE, 32'd0, 10'd5, 16'h0000, 1'b0);
    queue_cmd(OP_FREE, 32'd0, 10'd0, 16'h0000, 1'b0);
    queue_cmd(OP_FREE, 32'd0, 10'd1, 16'h0000, 1'b0);
    queue_cmd(OP_WRITE, 32'd0, 10'd1023, 16'h0400, 1'b0);
    queue_cmd(OP_FREE, 32'd0, 10'd1023, 16'h0000, 1'b0);
    queue_cmd(OP_WRITE, 32'd0, 10'd1010, 16'd1010, 1'b0);
    queue_cmd(OP_FREE, 32'd0, 10'd1010, 16'h0000, 1'b0);
    queue_cmd(OP_WRITE, 32'd0, 10'd0, END_MARK, 1'b0);
    queue_cmd(OP_WRITE, 32'd0, 10'd1, END_MARK, 1'b0);
    queue_cmd(OP_READ, 32'd0, 10'd1, 16'h0000, 1'b0);
    queue_cmd(OP_FREE, 32'd0, 10'd7, 16'h0000, 1'b0);
    queue_cmd(OP_WRITE, 32'd0, 10'd1000, 16'd1001, 1'b0);
    queue_cmd(OP_WRITE, 32'd0, 10'd1001, END_MARK, 1'b0);
    queue_cmd(OP_FREE, 32'd0, 10'd1000, 16'h0000, 1'b0);
    drain();

    repeat (260) queue_random_cmd();
    drain();

    gap_max = 0;
    stall_max = 0;
    repeat (200) queue_random_cmd();
    drain();

    // Large allocations until the table runs out of space, then release what is held.
    gap_max = 6;
    stall_max = 3;
    repeat (16)
      queue_cmd(OP_ALLOC, $urandom_range(64, MAX_CHAIN) * CLUSTER_BYTES
                - $urandom_range(0, CLUSTER_BYTES - 1), $urandom_range(0, 1023),
                $urandom_range(0, 65535), 1'b0);
    repeat (30) queue_cmd(OP_FREE, $urandom(), $urandom_range(0, 1023), $urandom_range(0, 65535),
                          1'b1);
    repeat (50) queue_random_cmd();
    drain();

    repeat (100) @(posedge clk);
    $display("Sent %0d commands, checked %0d results: %0d allocations (%0d short of space,",
             n_sent, n_results, n_alloc, n_nospace);
    $display("%0d oversize), %0d frees (%0d broken chains), %0d reads, %0d writes.",
             n_toomany, n_free, n_badchain, n_read, n_write);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
